// File: design/tcl_pkg.sv
package tcl_pkg;

    // Default field widths
    localparam int VALUE_BITS_DEF = 31;
    localparam int POS_BITS_DEF   = 16;

    // Token kind codes
    localparam logic [3:0] KIND_SYM   = 4'd0;
    localparam logic [3:0] KIND_EQ    = 4'd1;
    localparam logic [3:0] KIND_NE    = 4'd2;
    localparam logic [3:0] KIND_LE    = 4'd3;
    localparam logic [3:0] KIND_GE    = 4'd4;
    localparam logic [3:0] KIND_RET   = 4'd5;
    localparam logic [3:0] KIND_IDENT = 4'd6;
    localparam logic [3:0] KIND_NUM   = 4'd7;
    localparam logic [3:0] KIND_EOF   = 4'd8;
    localparam logic [3:0] KIND_ERR   = 4'd9;

    // Length of the "return" keyword
    localparam logic [2:0] KW_LEN = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch the accepted input transaction
        logic step;   // commit one scanner step
        logic close;  // push the held token out as the last of its run
    } tcl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;          // current step produces a token
        logic final_step;    // current step finishes the input item
        logic hold_valid;    // a token waits in the hold register
        logic out_free;      // output register can take a token this cycle
        logic rescan_active; // keyword letters are being replayed
    } tcl_status_t;

endpackage

// File: design/tcl_in_if.sv
interface tcl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_text;

    modport source (output valid, output byte_value, output end_of_text, input ready);
    modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

// File: design/tcl_out_if.sv
interface tcl_out_if #(
    parameter int VALUE_BITS = tcl_pkg::VALUE_BITS_DEF,
    parameter int POS_BITS   = tcl_pkg::POS_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [3:0]            token_kind;
    logic [7:0]            char_code;
    logic [VALUE_BITS-1:0] number_value;
    logic                  value_saturated;
    logic [POS_BITS-1:0]   start_position;
    logic                  last_of_run;

    modport source (
        output valid, output token_kind, output char_code, output number_value,
        output value_saturated, output start_position, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input char_code, input number_value,
        input value_saturated, input start_position, input last_of_run,
        output ready
    );
endinterface

// File: design/tiny_c_byte_lexer.sv
// Sequence: an accepted byte is latched (S_IDLE), stepped through the scanner (S_STEP)
// and its run closed (S_LAST); its last token sits in the output register the cycle after the close.
// No new byte is accepted until the current item's run is closed; a failed "return" prefix
// adds scanner steps to replay its letters; the single scanner step unit emits at most one token per step.
// A step that emits a token stalls while a token is held and the output register holds an untaken token.
// Reset (rst_n low, asynchronous): scanner idle, position 0, error flag and output cleared.
module tiny_c_byte_lexer #(
    parameter int VALUE_BITS = tcl_pkg::VALUE_BITS_DEF,
    parameter int POS_BITS   = tcl_pkg::POS_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tcl_in_if.sink    text,
    tcl_out_if.source tokens
);
    import tcl_pkg::*;

    tcl_cmd_t    cmd;
    tcl_status_t status;
    logic        in_ready;

    assign text.ready = in_ready;

    tcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcl_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .byte_value      (text.byte_value),
        .end_of_text     (text.end_of_text),
        .out_ready       (tokens.ready),
        .out_valid       (tokens.valid),
        .token_kind      (tokens.token_kind),
        .char_code       (tokens.char_code),
        .number_value    (tokens.number_value),
        .value_saturated (tokens.value_saturated),
        .start_position  (tokens.start_position),
        .last_of_run     (tokens.last_of_run)
    );

endmodule

// File: design/tcl_datapath.sv
module tcl_datapath #(
    parameter int VALUE_BITS = tcl_pkg::VALUE_BITS_DEF,
    parameter int POS_BITS   = tcl_pkg::POS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcl_pkg::tcl_cmd_t     cmd,
    output tcl_pkg::tcl_status_t  status,
    input  logic [7:0]            byte_value,
    input  logic                  end_of_text,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [3:0]            token_kind,
    output logic [7:0]            char_code,
    output logic [VALUE_BITS-1:0] number_value,
    output logic                  value_saturated,
    output logic [POS_BITS-1:0]   start_position,
    output logic                  last_of_run
);
    import tcl_pkg::*;

    // Scanner modes
    localparam logic [1:0] M_IDLE   = 2'd0;
    localparam logic [1:0] M_PREFIX = 2'd1;
    localparam logic [1:0] M_HELD   = 2'd2;
    localparam logic [1:0] M_NUMBER = 2'd3;

    localparam logic [7:0] CH_R    = "r";
    localparam logic [7:0] CH_EQ   = "=";
    localparam logic [7:0] CH_BANG = "!";
    localparam logic [7:0] CH_LT   = "<";
    localparam logic [7:0] CH_GT   = ">";

    localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "r";
            3'd1:    c = "e";
            3'd2:    c = "t";
            3'd3:    c = "u";
            3'd4:    c = "r";
            3'd5:    c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= "a") && (c <= "z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_lower(c) || is_digit(c) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "(") || (c == ")") || (c == ";");
    endfunction

    // Scanner state
    logic [1:0]            mode_reg, mode_next;
    logic [2:0]            kw_len_reg, kw_len_next;
    logic [7:0]            held_reg, held_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [POS_BITS-1:0]   pstart_reg, pstart_next;
    logic [POS_BITS-1:0]   offset_reg, offset_next;
    logic                  err_reg, err_next;

    // Keyword replay: letters rs_idx..rs_len-1 starting at rs_base
    logic [2:0]            rs_idx_reg, rs_idx_next;
    logic [2:0]            rs_len_reg, rs_len_next;
    logic [POS_BITS-1:0]   rs_base_reg, rs_base_next;

    // Latched input transaction
    logic [7:0]            byte_reg;
    logic                  eot_reg;

    // Hold register: newest token, not yet known to be the last of its run
    logic                  hold_valid_reg;
    logic [3:0]            h_kind_reg;
    logic [7:0]            h_char_reg;
    logic [VALUE_BITS-1:0] h_val_reg;
    logic                  h_sat_reg;
    logic [POS_BITS-1:0]   h_pos_reg;

    // Output register
    logic                  out_valid_reg;
    logic [3:0]            o_kind_reg;
    logic [7:0]            o_char_reg;
    logic [VALUE_BITS-1:0] o_val_reg;
    logic                  o_sat_reg;
    logic [POS_BITS-1:0]   o_pos_reg;
    logic                  o_last_reg;

    // Step results
    logic                  rs_active;
    logic [7:0]            ch;
    logic [POS_BITS-1:0]   cpos;
    logic                  e_vld;
    logic [3:0]            e_kind;
    logic [7:0]            e_char;
    logic [VALUE_BITS-1:0] e_val;
    logic                  e_sat;
    logic [POS_BITS-1:0]   e_pos;
    logic                  consume;
    logic                  restart;
    logic [VALUE_BITS+3:0] acc_ext;
    logic [VALUE_BITS+3:0] acc_sum;
    logic                  move;
    logic                  out_free;

    // Character source: replayed keyword letter or the input byte
    assign rs_active = rs_idx_reg < rs_len_reg;
    assign ch        = rs_active ? kw_char(rs_idx_reg) : byte_reg;
    assign cpos      = rs_active ? rs_base_reg + POS_BITS'(rs_idx_reg) : offset_reg;

    // Decimal accumulate: acc*10 + digit, saturating
    assign acc_ext = (VALUE_BITS+4)'(acc_reg);
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + (VALUE_BITS+4)'(ch[3:0]);

    // One scanner step
    always_comb
    begin
        mode_next    = mode_reg;
        kw_len_next  = kw_len_reg;
        held_next    = held_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        pstart_next  = pstart_reg;
        offset_next  = offset_reg;
        err_next     = err_reg;
        rs_idx_next  = rs_idx_reg;
        rs_len_next  = rs_len_reg;
        rs_base_next = rs_base_reg;
        e_vld        = 1'b0;
        e_kind       = KIND_SYM;
        e_char       = 8'h00;
        e_val        = '0;
        e_sat        = 1'b0;
        e_pos        = pstart_reg;
        consume      = 1'b0;
        restart      = 1'b0;

        if (eot_reg && !rs_active)
        begin
            // end marker: close any pending token, then EOF
            if (err_reg || (mode_reg == M_IDLE))
            begin
                e_vld   = 1'b1;
                e_kind  = KIND_EOF;
                e_pos   = offset_reg;
                consume = 1'b1;
                restart = 1'b1;
            end
            else
            begin
                e_vld     = 1'b1;
                mode_next = M_IDLE;
                unique case (mode_reg)
                    M_NUMBER:
                    begin
                        e_kind = KIND_NUM;
                        e_val  = acc_reg;
                        e_sat  = ovf_reg;
                    end
                    M_HELD:
                    begin
                        e_kind = (held_reg == CH_BANG) ? KIND_ERR : KIND_SYM;
                        e_char = held_reg;
                    end
                    default:
                    begin
                        kw_len_next = 3'd0;
                        if (kw_len_reg == KW_LEN)
                        begin
                            e_kind = KIND_RET;
                        end
                        else
                        begin
                            // partial keyword: its letters replay as identifiers
                            e_kind = KIND_IDENT;
                            e_char = CH_R;
                            if (kw_len_reg > 3'd1)
                            begin
                                rs_idx_next  = 3'd1;
                                rs_len_next  = kw_len_reg;
                                rs_base_next = pstart_reg;
                            end
                        end
                    end
                endcase
            end
        end
        else if (err_reg && !rs_active)
        begin
            // dropped after an error, still counted
            consume = 1'b1;
        end
        else if (mode_reg == M_NUMBER && is_digit(ch))
        begin
            consume = 1'b1;
            if (|acc_sum[VALUE_BITS+3:VALUE_BITS])
            begin
                acc_next = VAL_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum[VALUE_BITS-1:0];
            end
        end
        else if (mode_reg == M_NUMBER)
        begin
            e_vld     = 1'b1;
            e_kind    = KIND_NUM;
            e_val     = acc_reg;
            e_sat     = ovf_reg;
            mode_next = M_IDLE;
        end
        else if (mode_reg == M_HELD)
        begin
            e_vld     = 1'b1;
            e_char    = held_reg;
            mode_next = M_IDLE;
            if (ch == CH_EQ)
            begin
                e_char  = 8'h00;
                consume = 1'b1;
                priority if (held_reg == CH_EQ)   e_kind = KIND_EQ;
                else if (held_reg == CH_BANG)     e_kind = KIND_NE;
                else if (held_reg == CH_LT)       e_kind = KIND_LE;
                else                              e_kind = KIND_GE;
            end
            else if (held_reg == CH_BANG)
            begin
                // lone bang: error, following byte dropped
                e_kind   = KIND_ERR;
                err_next = 1'b1;
                consume  = 1'b1;
            end
            else
            begin
                e_kind = KIND_SYM;
            end
        end
        else if (mode_reg == M_PREFIX)
        begin
            if ((kw_len_reg < KW_LEN) && (ch == kw_char(kw_len_reg)))
            begin
                kw_len_next = kw_len_reg + 3'd1;
                consume     = 1'b1;
            end
            else if ((kw_len_reg == KW_LEN) && !is_word(ch))
            begin
                e_vld       = 1'b1;
                e_kind      = KIND_RET;
                mode_next   = M_IDLE;
                kw_len_next = 3'd0;
            end
            else
            begin
                // no keyword: first letter out, the rest replayed
                e_vld       = 1'b1;
                e_kind      = KIND_IDENT;
                e_char      = CH_R;
                mode_next   = M_IDLE;
                kw_len_next = 3'd0;
                if (kw_len_reg > 3'd1)
                begin
                    rs_idx_next  = 3'd1;
                    rs_len_next  = kw_len_reg;
                    rs_base_next = pstart_reg;
                end
            end
        end
        else
        begin
            // between tokens
            consume = 1'b1;
            e_pos   = cpos;
            e_char  = ch;
            priority if (is_space(ch))
            begin
                e_vld = 1'b0;
            end
            else if (ch == CH_R)
            begin
                mode_next   = M_PREFIX;
                kw_len_next = 3'd1;
                pstart_next = cpos;
            end
            else if ((ch == CH_EQ) || (ch == CH_BANG) || (ch == CH_LT) || (ch == CH_GT))
            begin
                mode_next   = M_HELD;
                held_next   = ch;
                pstart_next = cpos;
            end
            else if (is_single(ch))
            begin
                e_vld  = 1'b1;
                e_kind = KIND_SYM;
            end
            else if (is_lower(ch))
            begin
                e_vld  = 1'b1;
                e_kind = KIND_IDENT;
            end
            else if (is_digit(ch))
            begin
                mode_next   = M_NUMBER;
                acc_next    = VALUE_BITS'(ch[3:0]);
                ovf_next    = 1'b0;
                pstart_next = cpos;
            end
            else
            begin
                e_vld    = 1'b1;
                e_kind   = KIND_ERR;
                err_next = 1'b1;
            end
        end

        // advance the character source
        if (consume)
        begin
            if (rs_active)
            begin
                rs_idx_next = rs_idx_reg + 3'd1;
            end
            else if (!eot_reg)
            begin
                offset_next = offset_reg + POS_BITS'(1);
            end
        end

        if (restart)
        begin
            mode_next   = M_IDLE;
            kw_len_next = 3'd0;
            err_next    = 1'b0;
            offset_next = '0;
            rs_idx_next = 3'd0;
            rs_len_next = 3'd0;
        end
    end

    // Scanner control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            kw_len_reg <= 3'd0;
            err_reg    <= 1'b0;
            offset_reg <= '0;
            rs_idx_reg <= 3'd0;
            rs_len_reg <= 3'd0;
        end
        else if (cmd.step)
        begin
            mode_reg   <= mode_next;
            kw_len_reg <= kw_len_next;
            err_reg    <= err_next;
            offset_reg <= offset_next;
            rs_idx_reg <= rs_idx_next;
            rs_len_reg <= rs_len_next;
        end
    end

    // Scanner payload state
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            held_reg    <= held_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            pstart_reg  <= pstart_next;
            rs_base_reg <= rs_base_next;
        end
        if (cmd.load)
        begin
            byte_reg <= byte_value;
            eot_reg  <= end_of_text;
        end
    end

    // Hold and output registers
    assign out_free = !out_valid_reg || out_ready;
    assign move     = cmd.step && e_vld && hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step && e_vld)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.close)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (move || cmd.close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && e_vld)
        begin
            h_kind_reg <= e_kind;
            h_char_reg <= e_char;
            h_val_reg  <= e_val;
            h_sat_reg  <= e_sat;
            h_pos_reg  <= e_pos;
        end
        if (move || cmd.close)
        begin
            o_kind_reg <= h_kind_reg;
            o_char_reg <= h_char_reg;
            o_val_reg  <= h_val_reg;
            o_sat_reg  <= h_sat_reg;
            o_pos_reg  <= h_pos_reg;
            o_last_reg <= cmd.close;
        end
    end

    assign out_valid       = out_valid_reg;
    assign token_kind      = o_kind_reg;
    assign char_code       = o_char_reg;
    assign number_value    = o_val_reg;
    assign value_saturated = o_sat_reg;
    assign start_position  = o_pos_reg;
    assign last_of_run     = o_last_reg;

    assign status.emit          = e_vld;
    assign status.final_step    = consume && !rs_active;
    assign status.hold_valid    = hold_valid_reg;
    assign status.out_free      = out_free;
    assign status.rescan_active = rs_active;

endmodule

// File: design/tcl_ctrl.sv
module tcl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcl_pkg::tcl_status_t status,
    output tcl_pkg::tcl_cmd_t    cmd
);
    import tcl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;

    logic [1:0] state_reg, state_next;

    // Sequencing: accept, step the scanner, close the run
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // a new token displaces the held one only if the output can take it
                if (!status.emit || !status.hold_valid || status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.final_step)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                if (!status.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every token of a run has left the hold register before the next transaction
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !status.hold_valid)
        else $error("hold register occupied while idle");

    // Keyword replay never spans two input items
    a_idle_no_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !status.rescan_active)
        else $error("keyword replay active while idle");

    // A held token is only displaced into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.emit && status.hold_valid) |-> status.out_free)
        else $error("token displaced into a busy output register");

    // Closing a run returns to idle on the next cycle
    a_last_exits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LAST) && (!status.hold_valid || status.out_free))
        |=> (state_reg == S_IDLE))
        else $error("run close did not return to idle");

endmodule

// File: tb/tiny_c_byte_lexer_tb.sv
module tiny_c_byte_lexer_tb;
    import tcl_pkg::*;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int PB            = POS_BITS_DEF;
    localparam int MAX_RUN       = 7;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam logic [47:0] KEYWORD = "return";

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_PREFIX,
        SCAN_HELD,
        SCAN_NUMBER
    } scan_mode_t;

    typedef struct packed {
        logic [3:0]    kind;
        logic [7:0]    char_code;
        logic [VB-1:0] number_value;
        logic          saturated;
        logic [PB-1:0] start_position;
        logic          last;
    } token_t;

    // Token predictor plus the queue of tokens still owed by the lexer
    class lexer_scoreboard;
        token_t            expected_tokens[$];
        token_t            run_tokens[$];
        int                fail_count;
        int                tokens_checked;
        int                error_tokens;
        int                saturated_numbers;
        scan_mode_t        mode;
        int unsigned       prefix_len;
        byte unsigned      held;
        longint unsigned   acc;
        bit                overflowed;
        bit [PB-1:0]       pending_start;
        bit [PB-1:0]       offset;
        bit                stopped;

        function new();
            fail_count        = 0;
            tokens_checked    = 0;
            error_tokens      = 0;
            saturated_numbers = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode          = SCAN_IDLE;
            prefix_len    = 0;
            held          = 0;
            acc           = 0;
            overflowed    = 0;
            pending_start = 0;
            offset        = 0;
            stopped       = 0;
        endfunction

        function byte unsigned kw_char(int unsigned i);
            return KEYWORD[47 - 8*i -: 8];
        endfunction

        function bit is_word(byte unsigned c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == "_";
        endfunction

        function bit is_space(byte unsigned c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void emit(logic [3:0] kind, byte unsigned ch, longint unsigned val,
                           bit sat, bit [PB-1:0] pos);
            token_t t;
            if (run_tokens.size() >= MAX_RUN)
                return;
            t.kind           = kind;
            t.char_code      = ch;
            t.number_value   = val[VB-1:0];
            t.saturated      = sat;
            t.start_position = pos;
            t.last           = 1'b0;
            run_tokens.push_back(t);
        endfunction

        // One text byte through the scanner; recursive when keyword letters replay
        function void feed(byte unsigned c, bit [PB-1:0] pos);
            longint unsigned val_max;
            longint unsigned d;
            int unsigned     k;
            int unsigned     i;
            bit [PB-1:0]     st;
            val_max = (64'd1 << VB) - 1;
            if (stopped)
                return;

            if (mode == SCAN_NUMBER) begin
                if (c >= "0" && c <= "9") begin
                    d = c - "0";
                    if (acc > (val_max - d) / 10) begin
                        acc        = val_max;
                        overflowed = 1'b1;
                    end
                    else
                        acc = acc * 10 + d;
                    return;
                end
                emit(KIND_NUM, 0, acc, overflowed, pending_start);
                mode = SCAN_IDLE;
            end
            else if (mode == SCAN_HELD) begin
                if (c == "=") begin
                    case (held)
                        "=":     emit(KIND_EQ, 0, 0, 0, pending_start);
                        "!":     emit(KIND_NE, 0, 0, 0, pending_start);
                        "<":     emit(KIND_LE, 0, 0, 0, pending_start);
                        default: emit(KIND_GE, 0, 0, 0, pending_start);
                    endcase
                    mode = SCAN_IDLE;
                    return;
                end
                mode = SCAN_IDLE;
                // lone bang: error, and the byte after it is dropped
                if (held == "!") begin
                    emit(KIND_ERR, "!", 0, 0, pending_start);
                    stopped = 1'b1;
                    return;
                end
                emit(KIND_SYM, held, 0, 0, pending_start);
            end
            else if (mode == SCAN_PREFIX) begin
                k  = prefix_len;
                st = pending_start;
                if (k < KW_LEN && c == kw_char(k)) begin
                    prefix_len = k + 1;
                    return;
                end
                mode       = SCAN_IDLE;
                prefix_len = 0;
                if (k >= KW_LEN && !is_word(c))
                    emit(KIND_RET, 0, 0, 0, st);
                else begin
                    // replay the matched letters as identifiers
                    emit(KIND_IDENT, "r", 0, 0, st);
                    for (i = 1; i < k; i++)
                        feed(kw_char(i), st + i);
                    feed(c, pos);
                    return;
                end
            end

            // idle between tokens
            if (is_space(c))
                return;
            if (c == "r") begin
                mode          = SCAN_PREFIX;
                prefix_len    = 1;
                pending_start = pos;
                return;
            end
            if (c == "=" || c == "!" || c == "<" || c == ">") begin
                mode          = SCAN_HELD;
                held          = c;
                pending_start = pos;
                return;
            end
            if (c == "+" || c == "-" || c == "*" || c == "/" || c == "(" || c == ")" ||
                c == ";") begin
                emit(KIND_SYM, c, 0, 0, pos);
                return;
            end
            if (c >= "a" && c <= "z") begin
                emit(KIND_IDENT, c, 0, 0, pos);
                return;
            end
            if (c >= "0" && c <= "9") begin
                mode          = SCAN_NUMBER;
                acc           = c - "0";
                overflowed    = 1'b0;
                pending_start = pos;
                return;
            end
            emit(KIND_ERR, c, 0, 0, pos);
            stopped = 1'b1;
        endfunction

        // Accepted input transaction: predict its run of tokens
        function void note_input(logic [7:0] b, logic eot);
            token_t      t;
            int unsigned i;
            run_tokens.delete();
            if (eot) begin
                if (!stopped) begin
                    case (mode)
                        SCAN_NUMBER:
                            emit(KIND_NUM, 0, acc, overflowed, pending_start);
                        SCAN_HELD:
                            if (held == "!")
                                emit(KIND_ERR, "!", 0, 0, pending_start);
                            else
                                emit(KIND_SYM, held, 0, 0, pending_start);
                        SCAN_PREFIX:
                            if (prefix_len >= KW_LEN)
                                emit(KIND_RET, 0, 0, 0, pending_start);
                            else
                                for (i = 0; i < prefix_len; i++)
                                    emit(KIND_IDENT, kw_char(i), 0, 0, pending_start + i);
                        default: ;
                    endcase
                end
                emit(KIND_EOF, 0, 0, 0, offset);
                clear_state();
            end
            else begin
                feed(b, offset);
                offset = offset + 1'b1;
            end
            if (run_tokens.size() > 0) begin
                t      = run_tokens.pop_back();
                t.last = 1'b1;
                run_tokens.push_back(t);
            end
            foreach (run_tokens[j])
                expected_tokens.push_back(run_tokens[j]);
        endfunction

        function void field_diff(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("token %0d: %s expected %0d, got %0d", tokens_checked, name, want, got);
                fail_count++;
            end
        endfunction

        // Output transaction against the oldest predicted token
        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: kind %0d char %0d at position %0d",
                       got.kind, got.char_code, got.start_position);
                fail_count++;
                return;
            end
            want = expected_tokens.pop_front();
            field_diff("token_kind", want.kind, got.kind);
            field_diff("char_code", want.char_code, got.char_code);
            field_diff("number_value", want.number_value, got.number_value);
            field_diff("value_saturated", want.saturated, got.saturated);
            field_diff("start_position", want.start_position, got.start_position);
            field_diff("last_of_run", want.last, got.last);
            tokens_checked++;
            if (want.kind == KIND_ERR)
                error_tokens++;
            if (want.saturated)
                saturated_numbers++;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tcl_in_if  text();
    tcl_out_if tokens();

    tiny_c_byte_lexer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .tokens (tokens)
    );

    lexer_scoreboard sb = new();

    int  cycle_count = 0;
    int  items_sent;
    int  live_items;
    int  end_markers;
    int  burst_left;
    bit  idle_on;
    int  stall_mode = 0;
    int  stall_left = 0;
    int  stall_tick = 0;

    // 20-unit clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens owed", cycle_count, sb.pending());
            $display("[tiny_c_byte_lexer] ERROR");
            $finish;
        end
    end

    // Token monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (tokens.valid && tokens.ready)
            sb.check_token('{tokens.token_kind, tokens.char_code, tokens.number_value,
                             tokens.value_saturated, tokens.start_position,
                             tokens.last_of_run});
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       tokens.ready <= 1'b1;
            1:       tokens.ready <= 1'($urandom_range(0, 1));
            2:       tokens.ready <= (stall_tick % 4 == 0);
            default: tokens.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // One input transaction, with burst/gap idling ahead of it
    task automatic send_item(input logic [7:0] b, input logic eot);
        bit dropped;
        if (idle_on && burst_left == 0) begin
            text.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        text.valid       <= 1'b1;
        text.byte_value  <= b;
        text.end_of_text <= eot;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        dropped = sb.stopped && !eot;
        sb.note_input(b, eot);
        items_sent++;
        if (!dropped)
            live_items++;
        if (eot)
            end_markers++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic end_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the sender until every owed token has come out
    task automatic wait_drained();
        text.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One random fragment of source text, mostly well formed
    task automatic send_fragment();
        string       singles;
        string       follow;
        string       pairs;
        int          sel;
        int          n;
        byte unsigned c;
        singles = "+-*/();<>=";
        follow  = " ;x1_(r=!";
        pairs   = "=!<>";
        sel     = $urandom_range(0, 99);
        if (sb.stopped && $urandom_range(0, 3) != 0)
            end_text();
        else if (sel < 12) begin
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 6;
            for (int i = 0; i < n; i++)
                send_item(KEYWORD[47 - 8*i -: 8], 1'b0);
            send_item(follow[$urandom_range(0, follow.len() - 1)], 1'b0);
        end
        else if (sel < 30)
            send_item(8'($urandom_range("a", "z")), 1'b0);
        else if (sel < 44) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
            repeat (n)
                send_item(8'($urandom_range("0", "9")), 1'b0);
        end
        else if (sel < 58) begin
            c = pairs[$urandom_range(0, 3)];
            send_item(c, 1'b0);
            // a bang is mostly completed, so errors stay occasional
            if (c == "!" ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 1) == 1))
                send_item("=", 1'b0);
        end
        else if (sel < 72)
            send_item(singles[$urandom_range(0, singles.len() - 1)], 1'b0);
        else if (sel < 86)
            send_item(($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b0);
        else if (sel < 93)
            end_text();
        else
            send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Stimulus
    initial
    begin
        int  random_target;
        bit  paused;
        items_sent       = 0;
        live_items       = 0;
        end_markers      = 0;
        burst_left       = 0;
        idle_on          = 1'b1;
        paused           = 1'b0;
        rst_n            <= 1'b0;
        text.valid       <= 1'b0;
        text.byte_value  <= 8'h00;
        text.end_of_text <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword replay, pairs, lone bang, odd bytes, whitespace
        send_text("returnx<=");
        send_text("return!=");
        send_text("==>=");
        end_text();
        send_text("ret");
        end_text();
        send_text("!;");
        end_text();
        send_item(8'h00, 1'b0);
        end_text();
        send_item(8'hFF, 1'b0);
        send_text("z");
        end_text();
        send_text("7\t");
        end_text();

        // Random text
        random_target = live_items + RANDOM_ITEMS;
        while (live_items < random_target) begin
            send_fragment();
            if (!paused && live_items > random_target - RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        end_text();

        // Back-to-back keyword replay followed by a lone bang at the end marker
        wait_drained();
        idle_on = 1'b0;
        send_text("returnx1 !");
        end_text();
        idle_on = 1'b1;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d text transactions (%0d end markers), %0d tokens checked,",
                 items_sent, end_markers, sb.tokens_checked);
        $display("  %0d error tokens, %0d saturated numbers, keyword replay and stalls",
                 sb.error_tokens, sb.saturated_numbers);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("[tiny_c_byte_lexer] OK");
        else
            $display("[tiny_c_byte_lexer] ERROR");
        $finish;
    end

endmodule
